// File: rtl/gci_pkg.sv
package gci_pkg;

    // Request kinds carried on the input tuser bit
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Top-level sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LERP,
        S_DONE
    } t_state;

    // Interpolation unit sequencer
    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } t_lerp_state;

endpackage

// File: rtl/gci_ram.sv
module gci_ram
    import gci_pkg::*;
#(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gci_lerp.sv
module gci_lerp
    import gci_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned CHANNEL_BITS  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [3*CHANNEL_BITS-1:0] i_c0,
    input  logic [3*CHANNEL_BITS-1:0] i_c1,
    input  logic [POSITION_BITS-1:0]  i_num,
    input  logic [POSITION_BITS-1:0]  i_den,
    output logic                      o_done,
    output logic [3*CHANNEL_BITS-1:0] o_rgb
);

    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned SW = $clog2(CB + 1);

    t_lerp_state r_state, n_state;

    logic [CB-1:0] r_c0   [3];
    logic [CB-1:0] r_diff [3];
    logic [2:0]    r_neg;
    logic [PB-1:0] r_num;
    logic [PB-1:0] r_den;
    logic [PB-1:0] r_rem  [3];
    logic [CB-1:0] r_low  [3];
    logic [SW-1:0] r_step;

    logic [PB-1:0] n_rem  [3];
    logic [CB-1:0] n_low  [3];
    logic [SW-1:0] n_step;

    logic [CB+PB-1:0] w_prod [3];
    logic [PB:0]      w_trial [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch operands: magnitude of the colour step and its direction per lane
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            for (int k = 0; k < 3; k++) begin
                r_c0[k]  <= i_c0[k*CB +: CB];
                r_neg[k] <= i_c1[k*CB +: CB] < i_c0[k*CB +: CB];
                r_diff[k] <= (i_c1[k*CB +: CB] < i_c0[k*CB +: CB])
                           ? (i_c0[k*CB +: CB] - i_c1[k*CB +: CB])
                           : (i_c1[k*CB +: CB] - i_c0[k*CB +: CB]);
            end
            r_num <= i_num;
            r_den <= i_den;
        end
        for (int k = 0; k < 3; k++) begin
            r_rem[k] <= n_rem[k];
            r_low[k] <= n_low[k];
        end
        r_step <= n_step;
    end

    // The product stays below den << CB, so its upper PB bits already sit below
    // den and only CB quotient bits remain to be found
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        for (int k = 0; k < 3; k++) begin
            w_prod[k]  = (CB+PB)'(r_diff[k]) * (CB+PB)'(r_num);
            w_trial[k] = {r_rem[k], r_low[k][CB-1]};
            n_rem[k]   = r_rem[k];
            n_low[k]   = r_low[k];
        end
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    n_rem[k] = w_prod[k][CB+PB-1:CB];
                    n_low[k] = w_prod[k][CB-1:0];
                end
                n_step  = '0;
                n_state = L_DIV;
            end
            L_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (w_trial[k] >= {1'b0, r_den}) begin
                        n_rem[k] = PB'(w_trial[k] - {1'b0, r_den});
                        n_low[k] = {r_low[k][CB-2:0], 1'b1};
                    end else begin
                        n_rem[k] = w_trial[k][PB-1:0];
                        n_low[k] = {r_low[k][CB-2:0], 1'b0};
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == SW'(CB - 1)) begin
                    n_state = L_FIN;
                end
            end
            L_FIN: begin
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    assign o_done = (r_state == L_FIN);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_rgb[k*CB +: CB] = r_neg[k] ? (r_c0[k] - r_low[k]) : (r_c0[k] + r_low[k]);
        end
    end

endmodule

// File: rtl/gradient_color_interpolator_top.sv
// Piecewise linear colour map.
//
// Input stream (s_axis): tuser carries the request kind (0 append a stop,
// 1 look up a colour); tdata carries position, red, green, blue from bit 0 up.
// An append stores one stop at the end of the table and gives no result; once
// MAX_STOPS stops are held further appends are dropped. A lookup gives one
// result on m_axis: tdata holds red, green, blue from bit 0 up, tuser in_range.
//
// Flow: a lookup searches the table reading one stop per cycle and, where the
// query falls inside a segment, runs the interpolation unit (one multiply, one
// quotient bit per cycle for all three channels, one finishing step), then
// hands the result to the output register. The request port accepts only while
// the sequencer is idle.
//
// Reset clears the stop count and all handshake state; the stop RAM is not
// cleared, as only entries below the count are ever evaluated. When the receiver
// stalls the result waits in the output register; the next request is still
// accepted, and its result holds in the sequencer until the register frees.
module gradient_color_interpolator_top
    import gci_pkg::*;
#(
    parameter int unsigned MAX_STOPS     = 16,
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned CHANNEL_BITS  = 8,
    localparam int unsigned IN_W  = ((POSITION_BITS + 3*CHANNEL_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((3*CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // position, red, green, blue
    input  logic [0:0]       i_s_axis_tuser,   // kind
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,   // out_red, out_green, out_blue
    output logic [0:0]       o_m_axis_tuser    // in_range
);

    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned RW = 3 * CB;
    localparam int unsigned EW = PB + RW;
    localparam int unsigned IW = $clog2(MAX_STOPS);
    localparam int unsigned CW = $clog2(MAX_STOPS + 1);

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;    // next entry to read
    logic [CW-1:0] r_ridx,  n_ridx;   // entry whose data is on the RAM output
    logic          r_dv,    n_dv;
    logic [PB-1:0] r_q,     n_q;
    logic [PB-1:0] r_prev_pos, n_prev_pos;
    logic [RW-1:0] r_prev_rgb, n_prev_rgb;
    logic [RW-1:0] r_res_rgb,  n_res_rgb;
    logic          r_res_inr,  n_res_inr;
    logic          r_ovalid,   n_ovalid;
    logic [RW-1:0] r_orgb,     n_orgb;
    logic          r_oinr,     n_oinr;

    logic          w_in_acc;
    logic          w_append;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;
    logic [PB-1:0] w_rpos;
    logic [RW-1:0] w_rrgb;
    logic          w_lerp_start;
    logic          w_lerp_done;
    logic [RW-1:0] w_lerp_rgb;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_append        = w_in_acc && (i_s_axis_tuser[0] == KIND_APPEND)
                           && (r_count < CW'(MAX_STOPS));
    assign w_wdata         = i_s_axis_tdata[EW-1:0];
    assign w_rpos          = w_rdata[PB-1:0];
    assign w_rrgb          = w_rdata[EW-1:PB];

    // One entry per stop: position in the low bits, then red, green, blue
    gci_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk   (i_clk),
        .i_we    (w_append),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    gci_lerp #(
        .POSITION_BITS (PB),
        .CHANNEL_BITS  (CB)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_c0    (r_prev_rgb),
        .i_c1    (w_rrgb),
        .i_num   (r_q - r_prev_pos),
        .i_den   (w_rpos - r_prev_pos),
        .o_done  (w_lerp_done),
        .o_rgb   (w_lerp_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_ridx     <= n_ridx;
        r_q        <= n_q;
        r_prev_pos <= n_prev_pos;
        r_prev_rgb <= n_prev_rgb;
        r_res_rgb  <= n_res_rgb;
        r_res_inr  <= n_res_inr;
        r_orgb     <= n_orgb;
        r_oinr     <= n_oinr;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_ridx       = r_ridx;
        n_q          = r_q;
        n_prev_pos   = r_prev_pos;
        n_prev_rgb   = r_prev_rgb;
        n_res_rgb    = r_res_rgb;
        n_res_inr    = r_res_inr;
        n_orgb       = r_orgb;
        n_oinr       = r_oinr;
        n_ovalid     = r_ovalid;
        w_lerp_start = 1'b0;

        // Drop the held result once the receiver takes it
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser[0] == KIND_APPEND) begin
                        if (w_append) begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_q   = i_s_axis_tdata[PB-1:0];
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_res_rgb = '0;
                            n_res_inr = 1'b0;
                            n_state   = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; evaluate the entry read last cycle
                n_idx  = r_idx + 1'b1;
                n_ridx = r_idx;
                if (r_dv) begin
                    if (r_q > w_rpos) begin
                        if (r_ridx + 1'b1 == r_count) begin
                            // Query beyond the last stop
                            n_res_rgb = '0;
                            n_res_inr = 1'b0;
                            n_state   = S_DONE;
                        end else begin
                            n_prev_pos = w_rpos;
                            n_prev_rgb = w_rrgb;
                        end
                    end else if (r_ridx == '0) begin
                        // First stop: exact hit gives its colour, below it black
                        n_res_rgb = (r_q == w_rpos) ? w_rrgb : '0;
                        n_res_inr = (r_q == w_rpos);
                        n_state   = S_DONE;
                    end else if (w_rpos <= r_prev_pos) begin
                        // Zero-width or backward segment: hold the lower stop's colour
                        n_res_rgb = r_prev_rgb;
                        n_res_inr = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        w_lerp_start = 1'b1;
                        n_state      = S_LERP;
                    end
                end
            end
            S_LERP: begin
                if (w_lerp_done) begin
                    n_res_rgb = w_lerp_rgb;
                    n_res_inr = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_orgb   = r_res_rgb;
                    n_oinr   = r_res_inr;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // RAM data is valid next cycle only while the scan continues
        n_dv = (r_state == S_SCAN) && (n_state == S_SCAN);
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = OUT_W'(r_orgb);
    assign o_m_axis_tuser[0] = r_oinr;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the piecewise linear colour map: a request queue
// feeds a bursty driver, an in-bench colour predictor tracks the stop table,
// and a monitor checks every colour that leaves the block against it.
module testbench;
    import gci_pkg::*;

    localparam int unsigned STOP_DEPTH   = 16;
    localparam int unsigned POS_W        = 16;
    localparam int unsigned CH_W         = 8;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned HOLD_OFF     = 400;   // receiver hold-off to back up the block
    localparam int unsigned HOLD_AFTER   = 200;   // requests accepted before that hold-off

    // One request as it travels on the input stream
    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [POS_W-1:0] position;
    } t_colour_req;

    // One colour as it leaves the block
    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            in_range;
    } t_colour_res;

    // Receiver readiness patterns
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE
    } t_ready_mode;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          m_tready = 1'b0;
    logic          o_s_axis_tready;
    logic          o_m_axis_tvalid;
    logic [23:0]   o_m_axis_tdata;    // out_red, out_green, out_blue
    logic [0:0]    o_m_axis_tuser;    // in_range
    t_colour_req   cur_req = '0;

    // Requests waiting for the driver, colours waiting for the monitor
    t_colour_req   pending_requests[$];
    t_colour_res   expected_colours[$];

    // Predictor copy of the stop table
    logic [POS_W-1:0] stop_pos    [STOP_DEPTH];
    logic [CH_W-1:0]  stop_colour [STOP_DEPTH][3];
    int unsigned      stop_total = 0;

    // Stop positions as seen while building the stimulus
    int               plan_pos [STOP_DEPTH];
    int unsigned      plan_total = 0;
    int               ascend_base = 0;

    int unsigned      requests_accepted = 0;
    int unsigned      requests_total = 0;
    int unsigned      mismatches = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 1;
    int unsigned      gap_left = 0;
    int unsigned      hold_left = 0;
    logic             hold_done = 1'b0;
    logic [5:0]       ready_phase = '0;
    t_ready_mode      ready_mode = READY_ALWAYS;

    gradient_color_interpolator_top #(
        .MAX_STOPS     (STOP_DEPTH),
        .POSITION_BITS (POS_W),
        .CHANNEL_BITS  (CH_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // position, red, green, blue
        .i_s_axis_tdata  ({cur_req.blue, cur_req.green, cur_req.red, cur_req.position}),
        .i_s_axis_tuser  (cur_req.kind),    // kind
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // out_red, out_green, out_blue
        .o_m_axis_tuser  (o_m_axis_tuser)   // in_range
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Interpolate one channel; the quotient is a magnitude, so the sign of the
    // slope is applied afterwards and the division truncates toward zero.
    function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] c0,
                                                      input logic [CH_W-1:0] c1,
                                                      input int unsigned num,
                                                      input int unsigned den);
        int unsigned mag;
        if (c1 >= c0) begin
            mag = ((c1 - c0) * num) / den;
            return c0 + CH_W'(mag);
        end
        mag = ((c0 - c1) * num) / den;
        return c0 - CH_W'(mag);
    endfunction

    // Advance the predictor by one accepted request
    function automatic void apply_colour_request(input t_colour_req req);
        t_colour_res  col;
        int unsigned  idx;
        int unsigned  p0;
        int unsigned  p1;
        logic [CH_W-1:0] lower [3];
        logic [CH_W-1:0] upper [3];
        logic [CH_W-1:0] mixed [3];
        if (req.kind == KIND_APPEND) begin
            // drop appends once the table is full
            if (stop_total < STOP_DEPTH) begin
                stop_pos[stop_total]       = req.position;
                stop_colour[stop_total][0] = req.red;
                stop_colour[stop_total][1] = req.green;
                stop_colour[stop_total][2] = req.blue;
                stop_total++;
            end
            return;
        end
        idx = 0;
        while (idx < stop_total && req.position > stop_pos[idx])
            idx++;
        col = '{red: '0, green: '0, blue: '0, in_range: 1'b0};
        if (idx < stop_total && !(idx == 0 && req.position < stop_pos[0])) begin
            col.in_range = 1'b1;
            if (idx == 0) begin
                mixed = stop_colour[0];
            end else begin
                p0    = stop_pos[idx-1];
                p1    = stop_pos[idx];
                lower = stop_colour[idx-1];
                upper = stop_colour[idx];
                for (int k = 0; k < 3; k++) begin
                    // zero-width or backward segment, or query under the lower stop: hold lower colour
                    if (p1 <= p0 || req.position < p0)
                        mixed[k] = lower[k];
                    else
                        mixed[k] = blend_channel(lower[k], upper[k],
                                                 req.position - p0, p1 - p0);
                end
            end
            col.red   = mixed[0];
            col.green = mixed[1];
            col.blue  = mixed[2];
        end
        expected_colours.insert(expected_colours.size(), col);
    endfunction

    function automatic void check_field(input string field, input logic [CH_W-1:0] want,
                                        input logic [CH_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    task automatic queue_append(input int pos, input int r, input int g, input int b);
        t_colour_req req;
        req = '{kind: KIND_APPEND, position: POS_W'(pos),
                red: CH_W'(r), green: CH_W'(g), blue: CH_W'(b)};
        pending_requests.insert(pending_requests.size(), req);
        if (plan_total < STOP_DEPTH) begin
            plan_pos[plan_total] = pos;
            plan_total++;
        end
    endtask

    task automatic queue_lookup(input int pos);
        t_colour_req req;
        // colour bits are don't-care on a lookup, so fill them at random
        req = '{kind: KIND_LOOKUP, position: POS_W'(pos),
                red: CH_W'($urandom), green: CH_W'($urandom), blue: CH_W'($urandom)};
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Driver: offer requests in bursts, with random gaps between bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            gap_left  <= 0;
            burst_left <= 1;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                apply_colour_request(cur_req);
                requests_accepted <= requests_accepted + 1;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req  <= pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        // about half the bursts run straight into the next
                        gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: readiness pattern is redrawn each time its phase counter wraps; one long hold-off
    // once enough requests are in, so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && requests_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF;
            m_tready  <= 1'b0;
        end else begin
            ready_phase <= ready_phase + 1'b1;
            if (ready_phase == '1)
                ready_mode <= t_ready_mode'($urandom_range(0, 2));
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                default:      m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: compare each colour handed over with the oldest expectation
    always @(posedge i_clk) begin : colour_check
        t_colour_res want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (expected_colours.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected colour, expected none, got %h/%b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_colours.pop_front();
                check_field("out_red",   want.red,   o_m_axis_tdata[7:0]);
                check_field("out_green", want.green, o_m_axis_tdata[15:8]);
                check_field("out_blue",  want.blue,  o_m_axis_tdata[23:16]);
                check_field("in_range",  CH_W'(want.in_range), CH_W'(o_m_axis_tuser[0]));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gradient_color_interpolator_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int          effective;
        int          p;
        int unsigned sel;
        logic        do_append;

        // Directed: empty table, then a small table with a duplicate and
        // out-of-order stops
        queue_lookup(0);                    // empty table gives black
        queue_lookup(65535);
        queue_append(1000, 255, 0, 128);
        queue_lookup(1000);                 // exactly on the first stop
        queue_lookup(999);                  // below the first stop
        queue_lookup(1001);                 // beyond the last stop
        queue_append(3000, 0, 255, 127);
        queue_lookup(2000);                 // falling and rising slopes, truncated
        queue_lookup(1001);
        queue_lookup(3000);                 // exactly on an upper stop
        queue_append(3000, 10, 20, 30);     // duplicate position
        queue_lookup(3000);
        queue_append(2000, 200, 100, 50);   // out of order
        queue_lookup(2500);
        queue_lookup(3001);                 // runs past the table
        queue_append(4000, 255, 255, 255);
        queue_lookup(4000);
        queue_lookup(3500);                 // segment from the out-of-order stop
        queue_append(0, 0, 0, 0);           // out of order, full-scale low
        queue_lookup(0);                    // under the first stop
        queue_lookup(65535);                // beyond the last stop
        ascend_base = 4000;

        // Random: fill the table mostly in ascending order, interleaved with lookups
        // around stops, inside the used span and anywhere
        effective = 0;
        while (effective < RANDOM_ITEMS) begin
            if (plan_total < STOP_DEPTH)
                do_append = ($urandom_range(0, 2) == 0);
            else
                do_append = ($urandom_range(0, 7) == 0);   // dropped by the block
            if (do_append) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    p = $urandom_range(0, 65535);
                end else if (sel == 1) begin
                    p = plan_pos[$urandom_range(0, plan_total - 1)];
                end else begin
                    p = ascend_base + $urandom_range(0, 9000);
                    if (p > 65535)
                        p = 65535;
                    ascend_base = p;
                end
                if (plan_total < STOP_DEPTH)
                    effective++;
                queue_append(p, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255));
            end else begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    p = plan_pos[$urandom_range(0, plan_total - 1)]
                        + int'($urandom_range(0, 2)) - 1;
                else if (sel == 1)
                    p = $urandom_range(0, ascend_base);
                else
                    p = $urandom_range(0, 65535);
                if (p < 0)
                    p = 0;
                if (p > 65535)
                    p = 65535;
                queue_lookup(p);
                effective++;
            end
        end
        requests_total = pending_requests.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request in, every colour out, then a quiet tail
        while (requests_accepted != requests_total)
            @(posedge i_clk);
        while (expected_colours.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (mismatches == 0)
            $display("gradient_color_interpolator_top regression: pass");
        else
            $display("gradient_color_interpolator_top regression: fail");
        $finish;
    end

endmodule
